// ===== sv/rsa_modular_exponentiation_macros.svh =====
// Assertion macros shared by the modular exponentiation block.
`ifndef RSA_MODULAR_EXPONENTIATION_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rme: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rme: next-cycle check failed");

`endif

// ===== sv/rme_pkg.sv =====
package rme_pkg;

    // Widths of the modulus and of the exponent actually used.
    localparam int MOD_BITS = 32;
    localparam int EXP_BITS = 32;

    // The multiplier operand must also hold a whole 32-bit message word.
    localparam int OP_BITS  = (MOD_BITS > 32) ? MOD_BITS : 32;
    localparam int CNT_BITS = $clog2(OP_BITS + 1);
    localparam int IDX_BITS = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    typedef logic [MOD_BITS-1:0] t_mod;
    typedef logic [OP_BITS-1:0]  t_op;

    // Request to the modular multiply unit: result = addend * multiplier mod m.
    typedef struct packed {
        logic start;
        t_mod addend;
        t_op  multiplier;
    } t_mm_req;

    // Status back from the modular multiply unit.
    typedef struct packed {
        logic done;
        t_mod result;
    } t_mm_sts;

    // (a + b) mod m for a, b below m, without a carry bit.
    function automatic t_mod add_mod(input t_mod a, input t_mod b, input t_mod m);
        t_mod gap;
        gap = m - b;
        return (a >= gap) ? (a - gap) : (a + b);
    endfunction

endpackage

// ===== sv/rsa_modular_exponentiation.sv =====
// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_stall    i_message_value
// output    out        o_out_valid / i_out_stall  o_result_value, o_modulus_zero
// config    in         APB psel/penable/pready    exponent @ 0x0, modulus @ 0x4
//
// A word takes one multiplication per set exponent bit besides the reduction and the squarings;
// every modular multiplication runs 32 steps on the single shared multiply unit.
// With a zero modulus the result word is offered in the cycle after acceptance.
// Synchronous active-low reset gives exponent 1 and modulus 0.
// The input is stalled from acceptance until the result word has been taken;
// a stalled result holds its value.
module rsa_modular_exponentiation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_message_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_value,
    output logic        o_modulus_zero,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rme_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_PLAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(EXP_BITS - 1);

    logic [2:0]          r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    t_mod                r_res, n_res;
    t_mod                r_base, n_base;
    logic                r_mzero, n_mzero;
    logic [EXP_BITS-1:0] r_exponent;
    t_mod                r_modulus;

    t_mm_req             mm_req;
    t_mm_sts             mm_sts;
    logic                cfg_wr;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXP_BITS'(1);
            r_modulus  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_EXPONENT: r_exponent <= EXP_BITS'(pwdata);
                REG_MODULUS:  r_modulus  <= MOD_BITS'(pwdata);
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_MODULUS) ? 32'(r_modulus) : 32'(r_exponent);

    // Shared modular multiply unit.
    rme_mulmod_unit u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_req     (mm_req),
        .o_sts     (mm_sts)
    );

    // Sequencer: with a non-zero modulus, reduce the base, then square-and-multiply from the low exponent bit.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_res   = r_res;
        n_base  = r_base;
        n_mzero = r_mzero;
        mm_req.start      = 1'b0;
        mm_req.addend     = r_base;
        mm_req.multiplier = OP_BITS'(r_base);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_mzero = (r_modulus == '0);
                    if (r_modulus == '0) begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_res = (r_modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                        mm_req.start      = 1'b1;
                        mm_req.addend     = MOD_BITS'(1);
                        mm_req.multiplier = OP_BITS'(i_message_value);
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_sts.done) begin
                    n_base  = mm_sts.result;
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                if (r_exponent[r_idx]) begin
                    mm_req.start  = 1'b1;
                    mm_req.addend = r_res;
                    n_state = S_MUL;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_OUT;
                end else begin
                    mm_req.start = 1'b1;
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_sts.done) begin
                    n_res = mm_sts.result;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_OUT;
                    end else begin
                        mm_req.start = 1'b1;
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mm_sts.done) begin
                    n_base  = mm_sts.result;
                    n_idx   = r_idx + IDX_BITS'(1);
                    n_state = S_PLAN;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_base  <= n_base;
        r_mzero <= n_mzero;
    end

    // Result word, held in place while stalled.
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = (r_state == S_OUT);
    assign o_result_value = 32'(r_res);
    assign o_modulus_zero = r_mzero;

endmodule

// ===== sv/rme_mulmod_unit.sv =====
`include "rsa_modular_exponentiation_macros.svh"

module rme_mulmod_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rme_pkg::t_mod   i_modulus,
    input  rme_pkg::t_mm_req i_req,
    output rme_pkg::t_mm_sts o_sts
);
    import rme_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    t_mod                r_acc;
    t_mod                r_a;
    t_op                 r_b;

    t_mod                dbl;
    t_mod                n_acc;

    // One double-and-add step, multiplier bits taken from the top down.
    always_comb begin
        dbl   = add_mod(r_acc, r_acc, i_modulus);
        n_acc = r_b[OP_BITS-1] ? add_mod(dbl, r_a, i_modulus) : dbl;
    end

    // Control: busy while the multiplier bits are stepped through, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(OP_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulator, addend and multiplier shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.addend;
            r_b   <= i_req.multiplier;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[OP_BITS-2:0], 1'b0};
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.result = r_acc;

    `RME_ASSERT_NOW(a_start_when_free, i_clk, i_rst_n, i_req.start, !r_busy)
    `RME_ASSERT_NEXT(a_start_loads, i_clk, i_rst_n, i_req.start,
        r_busy && (r_cnt == CNT_BITS'(OP_BITS)))
    `RME_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n,
        r_busy && (r_cnt == CNT_BITS'(1)) && !i_req.start, r_done && !r_busy)
    `RME_ASSERT_NOW(a_busy_count, i_clk, i_rst_n, r_busy, r_cnt != '0)

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rme_pkg::*;

    // Byte addresses of the two key registers on the APB port.
    localparam logic [2:0] ADDR_EXPONENT = 3'h0;
    localparam logic [2:0] ADDR_MODULUS  = 3'h4;

    localparam int RANDOM_WORDS = 650;

    // One result word as the block presents it.
    typedef struct {
        logic [31:0] value;
        logic        mod_zero;
    } t_result;

    // Keeps its own copy of the key registers and the results still owed by the block.
    class modexp_scoreboard;
        logic [31:0] exponent_reg = 32'd1;
        logic [31:0] modulus_reg  = 32'd0;
        t_result     pending_results[$];
        int          n_errors   = 0;
        int          n_noted    = 0;
        int          n_checked  = 0;
        int          n_zero_mod = 0;

        function logic [31:0] mul_mod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
            logic [63:0] prod;
            prod = {32'd0, a} * {32'd0, b};
            return 32'(prod % {32'd0, m});
        endfunction

        // Square-and-multiply, least significant exponent bit first; m must be non-zero.
        function logic [31:0] predict_power(logic [31:0] msg, logic [31:0] e,
                                            logic [31:0] m);
            logic [31:0] acc;
            logic [31:0] sq;
            acc = (m == 32'd1) ? 32'd0 : 32'd1;
            sq  = msg % m;
            for (int i = 0; i < EXP_BITS; i++) begin
                if (e[i]) acc = mul_mod(acc, sq, m);
                sq = mul_mod(sq, sq, m);
            end
            return acc;
        endfunction

        function void note_message(logic [31:0] msg);
            t_result r;
            if (modulus_reg == 32'd0) begin
                r.value    = 32'd0;
                r.mod_zero = 1'b1;
            end else begin
                r.value    = predict_power(msg, exponent_reg, modulus_reg);
                r.mod_zero = 1'b0;
            end
            pending_results.push_back(r);
            n_noted++;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            n_errors++;
            $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h",
                     $time, what, got, want);
        endtask

        task check_result(logic [31:0] value, logic mod_zero);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding", value, 32'd0);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (want.mod_zero) n_zero_mod++;
            if (value !== want.value) report_mismatch("result_value", value, want.value);
            if (mod_zero !== want.mod_zero)
                report_mismatch("modulus_zero", {31'd0, mod_zero}, {31'd0, want.mod_zero});
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_message_value = 32'd0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [31:0] o_result_value;
    logic        o_modulus_zero;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = 3'd0;
    logic [31:0] pwdata          = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    modexp_scoreboard sb = new();

    logic [31:0] word_q[$];
    int          burst_left = 0;
    int          n_settings = 0;
    int          stall_mode = 0;
    int          mode_left  = 0;
    logic [3:0]  stall_tick = 4'd0;

    rsa_modular_exponentiation dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_message_value (i_message_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_value  (o_result_value),
        .o_modulus_zero  (o_modulus_zero),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: check each accepted word, and stall in modes that change now and then.
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && !i_out_stall)
            sb.check_result(o_result_value, o_modulus_zero);
        stall_tick <= stall_tick + 4'd1;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 4000);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 1);
            2: i_out_stall <= ($urandom_range(0, 7) != 0);
            default: i_out_stall <= stall_tick[3];
        endcase
    end

    // Write a register, then read it back over the same port.
    task automatic apb_write_readback(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== data) sb.report_mismatch("register readback", prdata, data);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_key(input logic [31:0] e, input logic [31:0] m);
        apb_write_readback(ADDR_EXPONENT, e);
        sb.exponent_reg = e;
        apb_write_readback(ADDR_MODULUS, m);
        sb.modulus_reg = m;
        n_settings++;
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [31:0] v);
        i_in_valid      <= 1'b1;
        i_message_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_message(v);
    endtask

    // Bursts of random length, separated by gaps that are mostly short but now and then long.
    task automatic pace(input bit last);
        int gap;
        if (last) begin
            i_in_valid <= 1'b0;
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9: gap = $urandom_range(100, 2500);
            default: gap = $urandom_range(1, 20);
        endcase
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send the queued words, then hold off until every result has come back.
    task automatic send_queued();
        for (int k = 0; k < word_q.size(); k++) begin
            send_word(word_q[k]);
            pace(k == word_q.size() - 1);
        end
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'd3;
            4: return 32'd65537;
            5: return 32'hFFFF_FFFF;
            6: return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'($urandom_range(3, 255));
            4: return 32'($urandom_range(256, 65535));
            5: return 32'hFFFF_FFFF;
            6: return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_message(input logic [31:0] m);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 255));
            3: return m - 32'd1;
            4: return m;
            5: return (m != 32'd0) ? ($urandom % m) : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Main sequence: directed key settings first, then random ones.
    initial begin
        logic [31:0] cipher;
        logic [31:0] e;
        logic [31:0] m;
        int          n;
        int          n_random;
        n_random = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset keys: a zero modulus must flag an error.
        word_q = '{32'd0, 32'hFFFF_FFFF};
        send_queued();

        // Zero modulus with the widest exponent.
        load_key(32'hFFFF_FFFF, 32'd0);
        word_q = '{32'h1234_5678};
        send_queued();

        // Modulus one: everything reduces to zero.
        load_key(32'h0001_2345, 32'd1);
        word_q = '{32'd0, 32'd7, 32'hFFFF_FFFF};
        send_queued();

        // Zero exponent gives one, or zero under a modulus of one.
        load_key(32'd0, 32'd3233);
        word_q = '{32'd0, 32'd65, 32'd3233};
        send_queued();
        load_key(32'd0, 32'd1);
        word_q = '{32'd5};
        send_queued();

        // A small textbook key pair, including bases at and above the modulus.
        load_key(32'd17, 32'd3233);
        word_q = '{32'd72, 32'd105, 32'd0, 32'd3232, 32'd3233, 32'hFFFF_FFFF};
        send_queued();
        cipher = sb.predict_power(32'd72, 32'd17, 32'd3233);
        load_key(32'd2753, 32'd3233);
        word_q = '{cipher, 32'd1};
        send_queued();

        // Largest modulus and exponent, then exponent 65537 with a modulus that has its top bit set.
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        word_q = '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd2};
        send_queued();
        load_key(32'd65537, 32'h8000_0001);
        word_q = '{32'hDEAD_BEEF, 32'h8000_0000};
        send_queued();

        // Random keys, each with a short run of random words.
        while (n_random < RANDOM_WORDS) begin
            e = pick_exponent();
            m = pick_modulus();
            load_key(e, m);
            n = $urandom_range(4, 30);
            if (n > RANDOM_WORDS - n_random) n = RANDOM_WORDS - n_random;
            word_q.delete();
            repeat (n) word_q.push_back(pick_message(m));
            send_queued();
            n_random += n;
        end

        // Give any stray result word time to show up.
        repeat (200) @(posedge i_clk);
        $display("Run covered %0d words over %0d key settings.", sb.n_noted, n_settings);
        $display("%0d result words checked, %0d of them with a zero modulus.",
                 sb.n_checked, sb.n_zero_mod);
        if (sb.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog for a block that hangs.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
